>>> rtl/assert_macros.svh
// Assertion helpers for the RTL, included by mpx_header_parser_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define MPX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MPX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mpxhp_pkg.sv
package mpxhp_pkg;

  // Transfer type codes
  localparam logic [2:0] TT_FULL           = 3'd0;
  localparam logic [2:0] TT_FULL_SMALL     = 3'd1;
  localparam logic [2:0] TT_FRAG_FIRST_SUB = 3'd2;
  localparam logic [2:0] TT_FRAG_LAST      = 3'd4;
  localparam logic [2:0] TT_ABORT          = 3'd6;

  // Longest header: control, fragment number, size, mux id
  localparam logic [2:0] MAX_HEADER_LEN = 3'd6;
  localparam logic [15:0] PAYLOAD_MAX   = 16'hffff;

  typedef struct packed {
    logic        ok;
    logic [2:0]  xfer_type;
    logic [4:0]  txn_tag;
    logic [7:0]  frag_index;
    logic [15:0] total_size;
    logic [15:0] mux_id;
    logic [2:0]  header_length;
    logic [15:0] payload_length;
  } mpxhp_result_t;

endpackage

>>> rtl/mpx_header_parser_unit.sv
// Multiplexing IE header parser.
// Input channel: one element byte per beat (data_byte) with end_of_element
// on the final byte; a beat moves when in_valid is high and in_stall low.
// Output channel: one result beat per element, issued for its final byte,
// moved when out_valid is high and out_stall low.
// Throughput: one byte per cycle while in_stall is low; the per-byte update
// is a single pass of logic into the parser state registers.
// The result is registered into the output register, or into the skid
// register while the output register holds a result not yet taken.
// A two-entry output buffer (output register plus skid register) lets
// bytes keep flowing while one result waits; in_stall rises only when both
// entries hold results, and drops as soon as the receiver takes one.
// Reset (rst, synchronous) clears the parser to the start of an element
// and empties the output buffer.
module mpx_header_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_element,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [2:0]  xfer_type,
  output logic [4:0]  txn_tag,
  output logic [7:0]  frag_index,
  output logic [15:0] total_size,
  output logic [15:0] mux_id,
  output logic [2:0]  header_length,
  output logic [15:0] payload_length
);
  import mpxhp_pkg::*;

  `include "assert_macros.svh"

  logic          accept;
  logic          res_valid;
  mpxhp_result_t res;
  mpxhp_result_t out_res;
  mpxhp_result_t skid_res;
  logic          skid_valid;
  logic          take;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  mpxhp_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_element (end_of_element),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      if (!out_valid) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      if (!out_valid) out_res <= res;
      else skid_res <= res;
    end
  end

  assign ok              = out_res.ok;
  assign xfer_type       = out_res.xfer_type;
  assign txn_tag         = out_res.txn_tag;
  assign frag_index      = out_res.frag_index;
  assign total_size      = out_res.total_size;
  assign mux_id          = out_res.mux_id;
  assign header_length   = out_res.header_length;
  assign payload_length  = out_res.payload_length;

  `MPX_ASSERT_ALWAYS(a_skid_needs_out, skid_valid |-> out_valid, "skid full with output empty")
  `MPX_ASSERT(a_skid_fill, $rose(skid_valid) |-> $past(out_valid && out_stall && res_valid), "skid filled without a waiting result")
  `MPX_ASSERT(a_skid_drain, (skid_valid && !out_stall) |=> (out_valid && !skid_valid), "skid entry not moved to output")

endmodule

>>> rtl/mpxhp_core.sv
module mpxhp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_element,
  output logic                   res_valid,
  output mpxhp_pkg::mpxhp_result_t res
);
  import mpxhp_pkg::*;

  logic [2:0]  byte_pos, byte_pos_next;
  logic [2:0]  type_code, type_code_next;
  logic [4:0]  txn_id, txn_id_next;
  logic [7:0]  frag_num, frag_num_next;
  logic [15:0] size_field, size_field_next;
  logic [15:0] mux_field, mux_field_next;
  logic [2:0]  need, need_next;
  logic        type_bad, type_bad_next;
  logic [15:0] payload_count, payload_count_next;
  logic [2:0]  need_eff;
  logic        ok;

  // Per-byte state update
  always_comb begin
    byte_pos_next      = byte_pos;
    type_code_next     = type_code;
    txn_id_next        = txn_id;
    frag_num_next      = frag_num;
    size_field_next    = size_field;
    mux_field_next     = mux_field;
    need_next          = need;
    type_bad_next      = type_bad;
    payload_count_next = payload_count;
    need_eff           = need;
    if (byte_pos == 3'd0) begin
      type_code_next = data_byte[2:0];
      txn_id_next    = data_byte[7:3];
      byte_pos_next  = 3'd1;
      unique case (data_byte[2:0])
        TT_FULL:                        need_next = 3'd3;
        TT_FULL_SMALL:                  need_next = 3'd1;
        TT_FRAG_FIRST_SUB, TT_FRAG_LAST: need_next = 3'd2;
        TT_ABORT:                       need_next = 3'd1;
        default: begin
          need_next     = 3'd1;
          type_bad_next = 1'b1;
        end
      endcase
    end else if (!type_bad) begin
      // abort carries a size only when more bytes follow the control byte
      if (type_code == TT_ABORT && byte_pos == 3'd1) need_eff = 3'd3;
      need_next = need_eff;
      if (byte_pos < need_eff && byte_pos < MAX_HEADER_LEN) begin
        byte_pos_next = byte_pos + 3'd1;
        if (type_code == TT_FULL) begin
          if (byte_pos == 3'd1) mux_field_next[7:0] = data_byte;
          else if (byte_pos == 3'd2) mux_field_next[15:8] = data_byte;
        end else if (type_code == TT_ABORT) begin
          if (byte_pos == 3'd1) size_field_next[7:0] = data_byte;
          else if (byte_pos == 3'd2) size_field_next[15:8] = data_byte;
        end else begin
          unique case (byte_pos)
            3'd1: begin
              frag_num_next = data_byte;
              need_next     = (data_byte == 8'd0) ? MAX_HEADER_LEN : 3'd2;
            end
            3'd2: size_field_next[7:0]  = data_byte;
            3'd3: size_field_next[15:8] = data_byte;
            3'd4: mux_field_next[7:0]   = data_byte;
            3'd5: mux_field_next[15:8]  = data_byte;
            default: ;
          endcase
        end
      end else if (payload_count != PAYLOAD_MAX) begin
        payload_count_next = payload_count + 16'd1;
      end
    end
  end

  // Result for the closing byte; all zero unless ok
  assign ok        = !type_bad_next && (byte_pos_next >= need_next);
  assign res_valid = accept && end_of_element;

  always_comb begin
    res = '0;
    if (ok) begin
      res.ok              = 1'b1;
      res.xfer_type       = type_code_next;
      res.txn_tag         = txn_id_next;
      res.frag_index      = frag_num_next;
      res.total_size      = size_field_next;
      res.mux_id          = mux_field_next;
      res.header_length   = need_next;
      res.payload_length  = payload_count_next;
    end
  end

  // Parser state; cleared on reset and after the closing byte of each element
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_element)) begin
      byte_pos      <= 3'd0;
      type_code     <= 3'd0;
      txn_id        <= 5'd0;
      frag_num      <= 8'd0;
      size_field    <= 16'd0;
      mux_field     <= 16'd0;
      need          <= 3'd1;
      type_bad      <= 1'b0;
      payload_count <= 16'd0;
    end else if (accept) begin
      byte_pos      <= byte_pos_next;
      type_code     <= type_code_next;
      txn_id        <= txn_id_next;
      frag_num      <= frag_num_next;
      size_field    <= size_field_next;
      mux_field     <= mux_field_next;
      need          <= need_next;
      type_bad      <= type_bad_next;
      payload_count <= payload_count_next;
    end
  end

endmodule
